// ===== hdl/pode_pkg.sv =====
// Package for the offset and drift estimator: constants, types and helper functions.
package pode_pkg;

    localparam int STAMP_BITS      = 63;
    localparam int DRIFT_FRAC_BITS = 32;
    localparam int STAMP_W         = 63;
    localparam int DIFF_W          = STAMP_W + 1;
    localparam int OUT_W           = 63;
    localparam int DRIFT_W         = 32;
    localparam int MAG_W           = 63;
    localparam int DIV_STEPS       = MAG_W + DRIFT_FRAC_BITS;
    localparam int DIV_CNT_W       = $clog2(DIV_STEPS + 1);
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_IDX_W     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [STAMP_W-1:0] STAMP_MASK =
        STAMP_W'((65'd1 << STAMP_BITS) - 65'd1);

    typedef enum logic [1:0] {
        FUNC_T1 = 2'd0,
        FUNC_T2 = 2'd1,
        FUNC_T3 = 2'd2,
        FUNC_T4 = 2'd3
    } t_func;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dms;
        logic signed [DIFF_W-1:0] dsm;
        logic [STAMP_W-1:0]       t1;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DLY,
        B_OFF,
        B_DEN,
        B_MAG,
        B_DIV,
        B_PUSH
    } t_back_state;

    // Clamp a wide signed value to the signed 62-bit magnitude range.
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [DIFF_W+1:0] x);
        logic signed [DIFF_W+1:0] hi;
        logic signed [DIFF_W+1:0] lo;
        hi = (DIFF_W+2)'((66'sd1 <<< (OUT_W - 1)) - 66'sd1);
        lo = -hi - (DIFF_W+2)'(1);
        if (x > hi) begin
            return OUT_W'(hi);
        end else if (x < lo) begin
            return OUT_W'(lo);
        end
        return OUT_W'(x);
    endfunction

endpackage

// ===== hdl/pode_if.sv =====
// Channel interfaces for timestamp transactions in and estimate transactions out.
interface pode_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [62:0] stamp;

    modport source(output valid, output func, output stamp, input ready);
    modport sink(input valid, input func, input stamp, output ready);
endinterface

interface pode_out_if;
    logic               valid;
    logic               ready;
    logic signed [62:0] clock_offset;
    logic signed [62:0] path_delay;
    logic signed [31:0] drift_q32;
    logic               drift_invalid;

    modport source(output valid, output clock_offset, output path_delay,
                   output drift_q32, output drift_invalid, input ready);
    modport sink(input valid, input clock_offset, input path_delay,
                 input drift_q32, input drift_invalid, output ready);
endinterface

// ===== hdl/pode_queue.sv =====
// Two-entry job queue between the front and back parts.
module pode_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pode_pkg::t_job  i_job,
    input  logic            i_pop,
    output pode_pkg::t_job  o_job,
    output pode_pkg::t_q_stat o_stat
);
    import pode_pkg::*;

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0] r_wr;
    logic [QUEUE_IDX_W-1:0] r_rd;
    logic [QUEUE_CNT_W-1:0] r_cnt;
    logic                   do_push;
    logic                   do_pop;

    assign o_stat.full  = (r_cnt == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// ===== hdl/pode_front.sv =====
// Front part: accepts timestamps, keeps T1 to T3 and issues a job on each T4.
module pode_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pode_in_if.sink           i_in,
    input  pode_pkg::t_q_stat i_stat,
    output logic              o_push,
    output pode_pkg::t_job    o_job
);
    import pode_pkg::*;

    logic [STAMP_W-1:0] r_t1;
    logic [STAMP_W-1:0] r_t2;
    logic [STAMP_W-1:0] r_t3;
    logic [STAMP_W-1:0] stamp_m;
    logic               take;

    assign i_in.ready = !i_stat.full;
    assign take       = i_in.valid && i_in.ready;
    assign stamp_m    = i_in.stamp & STAMP_MASK;

    // Both one-way delays are formed here so the job carries everything the back needs.
    assign o_job.dms = $signed({1'b0, r_t2}) - $signed({1'b0, r_t1});
    assign o_job.dsm = $signed({1'b0, stamp_m}) - $signed({1'b0, r_t3});
    assign o_job.t1  = r_t1;
    assign o_push    = take && (t_func'(i_in.func) == FUNC_T4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
            r_t3 <= '0;
        end else if (take) begin
            unique case (t_func'(i_in.func))
                FUNC_T1: r_t1 <= stamp_m;
                FUNC_T2: r_t2 <= stamp_m;
                FUNC_T3: r_t3 <= stamp_m;
                default: r_t1 <= r_t1;
            endcase
        end
    end
endmodule

// ===== hdl/pode_back.sv =====
// Back part: offset, delay and the bit-serial drift division, with the output register.
module pode_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pode_pkg::t_job   i_job,
    input  pode_pkg::t_q_stat i_stat,
    output logic             o_pop,
    pode_out_if.source       o_out
);
    import pode_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    t_job                     r_job;
    logic signed [DIFF_W-1:0] r_delay;
    logic signed [OUT_W-1:0]  r_offset;
    logic signed [OUT_W-1:0]  r_delay_sat;
    logic signed [OUT_W-1:0]  r_prev_offset;
    logic [STAMP_W-1:0]       r_prev_t1;
    logic signed [DIFF_W-1:0] r_dnum;
    logic signed [DIFF_W-1:0] r_dden;
    logic                     r_neg;
    logic                     r_invalid;
    logic [DIV_STEPS-1:0]     r_dividend;
    logic [MAG_W-1:0]         r_divisor;
    logic [MAG_W-1:0]         r_rem;
    logic [DRIFT_W-1:0]       r_quot;
    logic                     r_over;
    logic [DIV_CNT_W-1:0]     r_cnt;

    logic                     r_valid;
    logic signed [OUT_W-1:0]  r_o_offset;
    logic signed [OUT_W-1:0]  r_o_delay;
    logic signed [DRIFT_W-1:0] r_o_drift;
    logic                     r_o_invalid;

    logic                     slot_free;
    logic                     load_out;
    logic signed [DIFF_W:0]   sum;
    logic signed [DIFF_W+1:0] off_full;
    logic [MAG_W:0]           trial;
    logic                     qbit;
    logic                     over_f;
    logic signed [DRIFT_W-1:0] drift_v;
    logic [DIFF_W-1:0]        num_abs;
    logic [DIFF_W-1:0]        den_abs;

    assign slot_free = !r_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (!i_stat.empty) n_state = B_DLY;
            B_DLY:   n_state = B_OFF;
            B_OFF:   n_state = B_DEN;
            B_DEN:   n_state = B_MAG;
            B_MAG:   n_state = (r_dden == '0) ? B_PUSH : B_DIV;
            B_DIV:   if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) n_state = B_PUSH;
            B_PUSH:  if (slot_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            B_IDLE:  o_pop = !i_stat.empty;
            B_PUSH:  load_out = slot_free;
            default: begin
                o_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // Floor of half the sum: an arithmetic shift of the exact 65-bit sum.
    assign sum      = (DIFF_W+1)'(r_job.dms) + (DIFF_W+1)'(r_job.dsm);
    assign off_full = (DIFF_W+2)'(r_job.dms) - (DIFF_W+2)'(r_delay);
    assign num_abs  = r_dnum[DIFF_W-1] ? DIFF_W'(-r_dnum) : DIFF_W'(r_dnum);
    assign den_abs  = r_dden[DIFF_W-1] ? DIFF_W'(-r_dden) : DIFF_W'(r_dden);

    // One restoring step per cycle; the remainder always stays below the divisor.
    assign trial = {r_rem, r_dividend[DIV_STEPS-1]};
    assign qbit  = (trial >= {1'b0, r_divisor});

    // Any quotient bit at or above the sign position means the drift saturates.
    assign over_f  = r_over || r_quot[DRIFT_W-1];
    always_comb begin
        if (r_invalid) begin
            drift_v = '0;
        end else if (over_f) begin
            drift_v = r_neg ? {1'b1, {(DRIFT_W-1){1'b0}}} : {1'b0, {(DRIFT_W-1){1'b1}}};
        end else begin
            drift_v = r_neg ? -$signed(r_quot) : $signed(r_quot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        case (r_state)
            B_DLY: r_delay <= DIFF_W'(sum >>> 1);
            B_OFF: begin
                r_offset    <= sat_out(off_full);
                r_delay_sat <= sat_out((DIFF_W+2)'(r_delay));
            end
            B_DEN: begin
                r_dnum <= DIFF_W'(r_offset) - DIFF_W'(r_prev_offset);
                r_dden <= $signed({1'b0, r_job.t1}) - $signed({1'b0, r_prev_t1});
            end
            B_MAG: begin
                r_neg      <= r_dnum[DIFF_W-1] ^ r_dden[DIFF_W-1];
                r_invalid  <= (r_dden == '0);
                r_dividend <= {num_abs[MAG_W-1:0], {DRIFT_FRAC_BITS{1'b0}}};
                r_divisor  <= den_abs[MAG_W-1:0];
                r_rem      <= '0;
                r_quot     <= '0;
                r_over     <= 1'b0;
                r_cnt      <= '0;
            end
            B_DIV: begin
                r_rem      <= qbit ? MAG_W'(trial - {1'b0, r_divisor}) : trial[MAG_W-1:0];
                r_dividend <= {r_dividend[DIV_STEPS-2:0], 1'b0};
                r_quot     <= {r_quot[DRIFT_W-2:0], qbit};
                r_over     <= r_over || r_quot[DRIFT_W-1];
                r_cnt      <= r_cnt + 1'b1;
            end
            default: r_cnt <= r_cnt;
        endcase
        if (load_out) begin
            r_o_offset  <= r_offset;
            r_o_delay   <= r_delay_sat;
            r_o_drift   <= drift_v;
            r_o_invalid <= r_invalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= B_IDLE;
            r_valid       <= 1'b0;
            r_prev_offset <= '0;
            r_prev_t1     <= '0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
            if (r_state == B_DEN) begin
                r_prev_offset <= r_offset;
                r_prev_t1     <= r_job.t1;
            end
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.clock_offset  = r_o_offset;
    assign o_out.path_delay    = r_o_delay;
    assign o_out.drift_q32     = r_o_drift;
    assign o_out.drift_invalid = r_o_invalid;
endmodule

// ===== hdl/ptp_offset_drift_estimator.sv =====
// A T4 transaction gives its estimate after the job queue, the setup steps (pop, delay, offset,
// denominator, magnitudes), 95 divide steps (none for a zero T1 interval) and one load of the
// result register. The back finishes one exchange before it pops the next from the queue.
// T1, T2 and T3 transactions are taken one per cycle while the two-entry job queue has room.
// Reset (synchronous, active low) zeroes the stored stamps, previous offset and previous T1.
// A result held in the output register stalls the back only once the next estimate is ready.
module ptp_offset_drift_estimator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pode_in_if.sink     i_in,
    pode_out_if.source  o_out
);
    import pode_pkg::*;

    // The front stores timestamps and turns each T4 into a job holding both
    // one-way delays and the T1 it was measured against. Snapshotting T1 here
    // lets a new T1 arrive while the back is still working on the old exchange.
    t_job    front_job;
    t_job    head_job;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    pode_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_stat  (q_stat),
        .o_push  (push),
        .o_job   (front_job)
    );

    // The queue lets the front keep taking transactions during a division.
    pode_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    // The back computes the delay and saturated offset, then the drift as a
    // fixed-point quotient, and owns the output register.
    pode_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (head_job),
        .i_stat  (q_stat),
        .o_pop   (pop),
        .o_out   (o_out)
    );
endmodule
